// ----- rtl/core/csr_pkg.sv -----
// ----------------------------------------------------------------------------
// csr_pkg
// Shared constants, codes and arithmetic helpers of the CSR matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_pkg;

    localparam int MAX_DIM      = 64;
    localparam int MAX_NONZEROS = 1024;

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int NZ_W  = $clog2(MAX_NONZEROS);
    localparam int NZP_W = $clog2(MAX_NONZEROS + 1);

    localparam int ACT_W  = 3;
    localparam int IA_W   = 10;
    localparam int IB_W   = 6;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int OIX_W  = 6;
    localparam int ACC_W  = 64;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 1;
    localparam int FRAC_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_ROW   = 3'd0,
        ACT_LOAD_COL   = 3'd1,
        ACT_SET        = 3'd2,
        ACT_ADD        = 3'd3,
        ACT_LOAD_VEC   = 3'd4,
        ACT_APPLY      = 3'd5,
        ACT_TRANSPOSE  = 3'd6,
        ACT_CLEAR      = 3'd7
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_PATTERN = 2'd2
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } cfg_index_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        begin
            if (c == '0)
                r = CNT_W'(1);
            else if (c > CFG_W'(MAX_DIM))
                r = CNT_W'(MAX_DIM);
            else
                r = CNT_W'(c);
            return r;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        begin
            if (v > ACC_W'(64'sh7FFF_FFFF))
                r = 32'sh7FFF_FFFF;
            else if (v < -ACC_W'(64'sh8000_0000))
                r = 32'sh8000_0000;
            else
                r = v[VAL_W-1:0];
            return r;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] r;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
                r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            else
                r = s[ACC_W-1:0];
            return r;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] q16_out(input logic signed [ACC_W-1:0] acc);
        begin
            return sat32(acc >>> FRAC_W);
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csr_if.sv -----
// ----------------------------------------------------------------------------
// csr_if
// Command and result channel interfaces of the CSR matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface csr_cmd_if;
    import csr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [IA_W-1:0]         index_a;
    logic [IB_W-1:0]         index_b;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, index_a, index_b, value, input ready);
    modport sink (input valid, action, index_a, index_b, value, output ready);
endinterface

interface csr_res_if;
    import csr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [OIX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;

    modport source (output valid, status, out_index, out_value, last, input ready);
    modport sink (input valid, status, out_index, out_value, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/csr_ram.sv -----
// ----------------------------------------------------------------------------
// csr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/csr_mul.sv -----
// ----------------------------------------------------------------------------
// csr_mul
// Registered signed Q16.16 by Q16.16 multiplier giving a Q32.32 product.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_mul
    import csr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [VAL_W-1:0] a,
    input  wire logic signed [VAL_W-1:0] b,
    output logic signed [ACC_W-1:0]      p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

`default_nettype wire

// ----- rtl/core/csr_sparse_matrix_engine.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matrix_engine
// CSR sparse matrix store with set, add, clear, A*x and A^T*x in Q16.16.
// ----------------------------------------------------------------------------
// The engine handles one command word at a time. Loads of a row start, a
// column index or a vector slot write it when in range and send the result
// word. Set and add read the row start and end, then scan the entries of
// that row for the column. Apply does this for each row, and each entry
// walks the column memory, the vector memory and the multiplier in turn; an
// entry with a column out of range skips the vector read. Transpose apply
// first clears one accumulator per column, then walks every nonzero with a
// read-modify-write of the accumulator memory for an in-range column, then
// emits one word per column. Clear writes the 1024 value entries one per
// cycle, and the same clearing pass runs after reset, during which no
// command is accepted.
`default_nettype none

module csr_sparse_matrix_engine
    import csr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    csr_cmd_if.sink                cmd,
    csr_res_if.source              result
);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_RB     = 16'h0004,
        S_RE     = 16'h0008,
        S_RV     = 16'h0010,
        S_RX     = 16'h0020,
        S_KA     = 16'h0040,
        S_KD     = 16'h0080,
        S_VX     = 16'h0100,
        S_ACC    = 16'h0200,
        S_TACC   = 16'h0400,
        S_ROWOUT = 16'h0800,
        S_TCLR   = 16'h1000,
        S_TRD    = 16'h2000,
        S_TOUT   = 16'h4000,
        S_EMIT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  row_count_reg, column_count_reg;
    logic [NZ_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              clr_item_reg, clr_item_next;
    logic              out_valid_reg, out_valid_next;

    action_t                 act_reg, act_next;
    logic [IB_W-1:0]         ib_reg, ib_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [DIM_W-1:0]        row_reg, row_next;
    logic [DIM_W-1:0]        cnt_reg, cnt_next;
    logic [NZP_W-1:0]        k_reg, k_next;
    logic [NZP_W-1:0]        beg_reg, beg_next;
    logic [NZP_W-1:0]        end_reg, end_next;
    logic [DIM_W-1:0]        c_reg, c_next;
    logic signed [VAL_W-1:0] v_reg, v_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    status_t                 st_reg, st_next;

    logic [ST_W-1:0]         out_status_reg, out_status_next;
    logic [OIX_W-1:0]        out_index_reg, out_index_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    logic [CNT_W-1:0] rows, cols;
    logic             slot_free;

    logic             rs_we, rs_re;
    logic [CNT_W-1:0] rs_waddr, rs_raddr;
    logic [NZP_W-1:0] rs_wdata, rs_rdata;

    logic             ec_we, ec_re;
    logic [NZ_W-1:0]  ec_waddr;
    logic [DIM_W-1:0] ec_wdata, ec_rdata;

    logic             ev_we, ev_re;
    logic [NZ_W-1:0]  ev_waddr;
    logic [VAL_W-1:0] ev_wdata, ev_rdata;

    logic             vs_we, vs_re;
    logic [DIM_W-1:0] vs_waddr, vs_raddr;
    logic [VAL_W-1:0] vs_rdata;

    logic             ta_we, ta_re;
    logic [DIM_W-1:0] ta_waddr, ta_raddr;
    logic [ACC_W-1:0] ta_wdata, ta_rdata;

    logic signed [VAL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] mul_p;

    logic [NZP_W-1:0] rs_sat;
    logic [NZP_W-1:0] rs_max;

    assign rows = eff_count(row_count_reg);
    assign cols = eff_count(column_count_reg);
    assign slot_free = !out_valid_reg || result.ready;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.status    = out_status_reg;
    assign result.out_index = out_index_reg;
    assign result.out_value = out_value_reg;
    assign result.last      = out_last_reg;

    always_comb
    begin
        if (cmd.value < 0)
            rs_sat = '0;
        else if (cmd.value > VAL_W'(MAX_NONZEROS))
            rs_sat = NZP_W'(MAX_NONZEROS);
        else
            rs_sat = cmd.value[NZP_W-1:0];
    end

    assign rs_max = (rs_rdata > beg_reg) ? rs_rdata : beg_reg;

    csr_ram #(.WIDTH(NZP_W), .DEPTH(MAX_DIM + 1)) u_row_start (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
    );

    csr_ram #(.WIDTH(DIM_W), .DEPTH(MAX_NONZEROS)) u_entry_column (
        .clk(clk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
        .re(ec_re), .raddr(k_reg[NZ_W-1:0]), .rdata(ec_rdata)
    );

    csr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NONZEROS)) u_entry_value (
        .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
        .re(ev_re), .raddr(k_reg[NZ_W-1:0]), .rdata(ev_rdata)
    );

    csr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vector (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(cmd.value),
        .re(vs_re), .raddr(vs_raddr), .rdata(vs_rdata)
    );

    csr_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DIM)) u_transpose_acc (
        .clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(ta_wdata),
        .re(ta_re), .raddr(ta_raddr), .rdata(ta_rdata)
    );

    assign mul_a = (state_reg == S_KD) ? signed'(ev_rdata) : v_reg;
    assign mul_b = (state_reg == S_KD) ? x_reg : signed'(vs_rdata);

    csr_mul u_mul (
        .clk(clk), .a(mul_a), .b(mul_b), .p(mul_p)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_item_next   = clr_item_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        act_next        = act_reg;
        ib_next         = ib_reg;
        val_next        = val_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        beg_next        = beg_reg;
        end_next        = end_reg;
        c_next          = c_reg;
        v_next          = v_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        st_next         = st_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        rs_we = 1'b0; rs_waddr = cmd.index_a[CNT_W-1:0]; rs_wdata = rs_sat;
        rs_re = 1'b0; rs_raddr = {1'b0, row_reg};
        ec_we = 1'b0; ec_waddr = cmd.index_a[NZ_W-1:0]; ec_wdata = cmd.value[DIM_W-1:0];
        ec_re = 1'b0;
        ev_we = 1'b0; ev_waddr = clr_cnt_reg; ev_wdata = '0;
        ev_re = 1'b0;
        vs_we = 1'b0; vs_waddr = cmd.index_a[DIM_W-1:0];
        vs_re = 1'b0; vs_raddr = ec_rdata;
        ta_we = 1'b0; ta_waddr = cnt_reg; ta_wdata = '0;
        ta_re = 1'b0; ta_raddr = cnt_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ev_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NZ_W'(MAX_NONZEROS - 1))
                begin
                    st_next = ST_OK;
                    state_next = clr_item_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next = action_t'(cmd.action);
                    ib_next  = cmd.index_b;
                    val_next = cmd.value;
                    row_next = cmd.index_a[DIM_W-1:0];
                    st_next  = ST_OK;
                    state_next = S_EMIT;
                    unique case (action_t'(cmd.action))
                        ACT_LOAD_ROW:
                        begin
                            if (cmd.index_a > IA_W'(MAX_DIM))
                                st_next = ST_RANGE;
                            else
                                rs_we = 1'b1;
                        end
                        ACT_LOAD_COL:
                        begin
                            if (NZP_W'(cmd.index_a) >= NZP_W'(MAX_NONZEROS))
                                st_next = ST_RANGE;
                            else
                                ec_we = 1'b1;
                        end
                        ACT_LOAD_VEC:
                        begin
                            if (cmd.index_a >= IA_W'(MAX_DIM))
                                st_next = ST_RANGE;
                            else
                                vs_we = 1'b1;
                        end
                        ACT_SET, ACT_ADD:
                        begin
                            if (cmd.index_a >= IA_W'(rows) || CNT_W'(cmd.index_b) >= cols)
                                st_next = ST_RANGE;
                            else
                                state_next = S_RB;
                        end
                        ACT_APPLY:
                        begin
                            row_next = '0;
                            state_next = S_RB;
                        end
                        ACT_TRANSPOSE:
                        begin
                            cnt_next = '0;
                            state_next = S_TCLR;
                        end
                        ACT_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_item_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_RB:
            begin
                rs_re = 1'b1;
                rs_raddr = {1'b0, row_reg};
                acc_next = '0;
                state_next = S_RE;
            end
            S_RE:
            begin
                beg_next = rs_rdata;
                rs_re = 1'b1;
                rs_raddr = {1'b0, row_reg} + 1'b1;
                state_next = S_RV;
            end
            S_RV:
            begin
                end_next = rs_max;
                k_next = beg_reg;
                vs_re = 1'b1;
                vs_raddr = row_reg;
                state_next = S_RX;
            end
            S_RX:
            begin
                x_next = vs_rdata;
                state_next = S_KA;
            end
            S_KA:
            begin
                if (k_reg >= end_reg)
                begin
                    if (act_reg == ACT_APPLY)
                        state_next = S_ROWOUT;
                    else if (act_reg == ACT_TRANSPOSE)
                    begin
                        if ({1'b0, row_reg} == rows - 1'b1)
                        begin
                            cnt_next = '0;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            state_next = S_RB;
                        end
                    end
                    else
                    begin
                        st_next = ST_PATTERN;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ec_re = 1'b1;
                    ev_re = 1'b1;
                    state_next = S_KD;
                end
            end
            S_KD:
            begin
                c_next = ec_rdata;
                v_next = ev_rdata;
                k_next = k_reg + 1'b1;
                state_next = S_KA;
                if (act_reg == ACT_SET || act_reg == ACT_ADD)
                begin
                    if (ec_rdata == ib_reg)
                    begin
                        ev_we = 1'b1;
                        ev_waddr = k_reg[NZ_W-1:0];
                        if (act_reg == ACT_SET)
                            ev_wdata = val_reg;
                        else
                            ev_wdata = sat32(ACC_W'(signed'(ev_rdata)) + ACC_W'(val_reg));
                        st_next = ST_OK;
                        state_next = S_EMIT;
                    end
                end
                else if (CNT_W'(ec_rdata) < cols)
                begin
                    if (act_reg == ACT_APPLY)
                    begin
                        vs_re = 1'b1;
                        vs_raddr = ec_rdata;
                        state_next = S_VX;
                    end
                    else
                    begin
                        ta_re = 1'b1;
                        ta_raddr = ec_rdata;
                        state_next = S_TACC;
                    end
                end
            end
            S_VX:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = sat_add64(acc_reg, mul_p);
                state_next = S_KA;
            end
            S_TACC:
            begin
                ta_we = 1'b1;
                ta_waddr = c_reg;
                ta_wdata = sat_add64(signed'(ta_rdata), mul_p);
                state_next = S_KA;
            end
            S_ROWOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_index_next  = row_reg;
                    out_value_next  = q16_out(acc_reg);
                    out_last_next   = ({1'b0, row_reg} == rows - 1'b1);
                    if ({1'b0, row_reg} == rows - 1'b1)
                        state_next = S_IDLE;
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        state_next = S_RB;
                    end
                end
            end
            S_TCLR:
            begin
                ta_we = 1'b1;
                ta_waddr = cnt_reg;
                ta_wdata = '0;
                cnt_next = cnt_reg + 1'b1;
                if ({1'b0, cnt_reg} == cols - 1'b1)
                begin
                    row_next = '0;
                    state_next = S_RB;
                end
            end
            S_TRD:
            begin
                ta_re = 1'b1;
                ta_raddr = cnt_reg;
                state_next = S_TOUT;
            end
            S_TOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_index_next  = cnt_reg;
                    out_value_next  = q16_out(signed'(ta_rdata));
                    out_last_next   = ({1'b0, cnt_reg} == cols - 1'b1);
                    if ({1'b0, cnt_reg} == cols - 1'b1)
                        state_next = S_IDLE;
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_TRD;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_index_next  = '0;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    clr_item_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            clr_item_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            row_count_reg    <= CFG_W'(MAX_DIM);
            column_count_reg <= CFG_W'(MAX_DIM);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ROW_COUNT:    row_count_reg <= cfg_data;
                    CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default:          row_count_reg <= row_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        ib_reg         <= ib_next;
        val_reg        <= val_next;
        row_reg        <= row_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        beg_reg        <= beg_next;
        end_reg        <= end_next;
        c_reg          <= c_next;
        v_reg          <= v_next;
        x_reg          <= x_next;
        acc_reg        <= acc_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire
